>>> src/mpeg_audio_sync_and_header_decode_assert.svh
// Assertion macros for the MPEG audio sync and header decoder.
`ifndef MPEG_AUDIO_SYNC_AND_HEADER_DECODE_ASSERT_SVH
`define MPEG_AUDIO_SYNC_AND_HEADER_DECODE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define MASD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("masd assertion failed");

// Next-cycle implication, checked out of reset.
`define MASD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("masd assertion failed");

`else

`define MASD_ASSERT_NOW(lbl, ante, cons)
`define MASD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> src/masd_pkg.sv
// Types, constants and table functions shared by the MPEG audio header decoder.
`default_nettype none

package masd_pkg;

	localparam int unsigned SB_W   = 40;
	localparam int unsigned KBPS_W = 9;
	localparam int unsigned SR_W   = 16;
	localparam int unsigned DUR_W  = 31;
	localparam int unsigned MIN_W  = 25;
	localparam int unsigned REM_W  = 6;
	localparam int unsigned DVR_W  = 16;
	localparam int unsigned JQ_DEPTH = 2;
	localparam int unsigned JQ_AW    = 1;

	localparam logic [7:0] SYNC_BYTE = 8'hFF;
	localparam logic [2:0] SYNC_TOP  = 3'b111;
	localparam logic [1:0] VER_MPEG1 = 2'b11;
	localparam logic [1:0] VER_MPEG2 = 2'b10;
	localparam logic [1:0] LAYER_III = 2'b01;

	// Bytes over kbit/s times 1000/8 gives whole seconds.
	localparam logic [6:0] KBPS_TO_BYTES   = 7'd125;
	localparam logic [DVR_W-1:0] SECS_PER_MIN = 16'd60;

	// Whole seconds over four, times this and shifted down, gives whole minutes.
	localparam int unsigned RECIP_SHIFT = 33;
	localparam int unsigned RECIP_P_W   = RECIP_SHIFT + MIN_W;
	localparam logic [29:0] MIN_RECIP   = 30'd572662307;

	typedef struct packed {
		logic              ok;
		logic [KBPS_W-1:0] kbps;
		logic [SR_W-1:0]   sr;
	} hdr_t;

	typedef struct packed {
		logic              found;
		logic [KBPS_W-1:0] kbps;
		logic [SR_W-1:0]   sr;
		logic [SB_W-1:0]   sbytes;
	} job_t;

	typedef struct packed {
		logic              start;
		logic [SB_W-1:0]   dividend;
		logic [DVR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              found;
		logic [KBPS_W-1:0] kbps;
		logic [SR_W-1:0]   sr;
		logic [DUR_W-1:0]  dur;
		logic [MIN_W-1:0]  mins;
		logic [REM_W-1:0]  rem;
	} result_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV_SEC,
		B_DIV_MIN,
		B_OUT
	} back_state_t;

	function automatic logic [KBPS_W-1:0] kbps_v1(input logic [3:0] idx);
		logic [KBPS_W-1:0] v;
		unique case (idx)
			4'd0:  v = 9'd0;
			4'd1:  v = 9'd32;
			4'd2:  v = 9'd40;
			4'd3:  v = 9'd48;
			4'd4:  v = 9'd56;
			4'd5:  v = 9'd64;
			4'd6:  v = 9'd80;
			4'd7:  v = 9'd96;
			4'd8:  v = 9'd112;
			4'd9:  v = 9'd128;
			4'd10: v = 9'd160;
			4'd11: v = 9'd192;
			4'd12: v = 9'd224;
			4'd13: v = 9'd256;
			4'd14: v = 9'd320;
			4'd15: v = 9'd0;
		endcase
		return v;
	endfunction

	function automatic logic [KBPS_W-1:0] kbps_v2(input logic [3:0] idx);
		logic [KBPS_W-1:0] v;
		unique case (idx)
			4'd0:  v = 9'd0;
			4'd1:  v = 9'd8;
			4'd2:  v = 9'd16;
			4'd3:  v = 9'd24;
			4'd4:  v = 9'd32;
			4'd5:  v = 9'd40;
			4'd6:  v = 9'd48;
			4'd7:  v = 9'd56;
			4'd8:  v = 9'd64;
			4'd9:  v = 9'd80;
			4'd10: v = 9'd96;
			4'd11: v = 9'd112;
			4'd12: v = 9'd128;
			4'd13: v = 9'd144;
			4'd14: v = 9'd160;
			4'd15: v = 9'd0;
		endcase
		return v;
	endfunction

	function automatic logic [SR_W-1:0] srate(input logic mpeg1, input logic [1:0] idx);
		logic [SR_W-1:0] v;
		unique case (idx)
			2'd0: v = mpeg1 ? 16'd44100 : 16'd22050;
			2'd1: v = mpeg1 ? 16'd48000 : 16'd24000;
			2'd2: v = mpeg1 ? 16'd32000 : 16'd16000;
			2'd3: v = 16'd0;
		endcase
		return v;
	endfunction

	function automatic hdr_t decode_hdr(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		hdr_t h;
		logic [1:0] ver;
		logic mpeg1;
		ver   = b1[4:3];
		mpeg1 = (ver == VER_MPEG1);
		h.kbps = mpeg1 ? kbps_v1(b2[7:4]) : kbps_v2(b2[7:4]);
		h.sr   = srate(mpeg1, b2[3:2]);
		h.ok   = (b0 == SYNC_BYTE) && (b1[7:5] == SYNC_TOP) && (b1[2:1] == LAYER_III) &&
			((ver == VER_MPEG1) || (ver == VER_MPEG2)) && (h.kbps != '0);
		return h;
	endfunction

endpackage

`default_nettype wire

>>> src/mpeg_audio_sync_and_header_decode.sv
// Top level of the MPEG audio frame sync search and Layer III header decoder.
`default_nettype none

// The scanner takes one stream byte per cycle and keeps doing so while a
// header is being worked out, as long as fewer than two classified results
// wait in the queue in front of the back end. Each found header keeps the
// back end busy through these steps in order: taking the queued transaction
// and starting the divider, the 40-step restoring divider that gives whole
// seconds, the reciprocal multiply that splits them into minutes and seconds,
// and the result register. A failed search goes from the idle state straight
// to the result register. The result register holds one transaction until it
// is popped; stream_bytes should only be written while the block is idle.

`include "mpeg_audio_sync_and_header_decode_assert.svh"

module mpeg_audio_sync_and_header_decode import masd_pkg::*; #(
	parameter int unsigned SCAN_WINDOW = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [SB_W-1:0]  cfg_wdata,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output logic                  empty,
	input  wire logic             pop,
	output logic                  found,
	output logic [KBPS_W-1:0]     bitrate_kbps,
	output logic [SR_W-1:0]       sample_rate_hz,
	output logic [DUR_W-1:0]      duration_sec,
	output logic [MIN_W-1:0]      duration_minutes,
	output logic [REM_W-1:0]      duration_rem_sec
);

	logic [SB_W-1:0] stream_bytes_q;
	logic            accept;
	logic            job_push;
	job_t            front_job;
	job_t            head_job;
	logic            jq_full;
	logic            jq_empty;
	logic            jq_pop;
	logic            res_valid;
	result_t         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_bytes_q <= '0;
		end else if (cfg_we) begin
			stream_bytes_q <= cfg_wdata;
		end
	end

	assign full   = jq_full;
	assign accept = push && !jq_full;

	masd_front #(
		.SCAN_WINDOW (SCAN_WINDOW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_bytes (stream_bytes_q),
		.accept       (accept),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.job_push     (job_push),
		.job          (front_job)
	);

	masd_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (front_job),
		.pop      (jq_pop),
		.head     (head_job),
		.full     (jq_full),
		.empty    (jq_empty)
	);

	masd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_empty (jq_empty),
		.job_pop   (jq_pop),
		.res_pop   (pop),
		.res_valid (res_valid),
		.res       (res)
	);

	assign empty            = !res_valid;
	assign found            = res.found;
	assign bitrate_kbps     = res.kbps;
	assign sample_rate_hz   = res.sr;
	assign duration_sec     = res.dur;
	assign duration_minutes = res.mins;
	assign duration_rem_sec = res.rem;

	`MASD_ASSERT_NOW(a_no_push_when_full, job_push, !jq_full)
	`MASD_ASSERT_NOW(a_found_has_rate, !empty && found, bitrate_kbps != '0)
	`MASD_ASSERT_NOW(a_miss_is_zero, !empty && !found, (bitrate_kbps == '0) && (duration_sec == '0) && (sample_rate_hz == '0))
	`MASD_ASSERT_NOW(a_min_sec_split, !empty, (32'(duration_minutes) * 32'd60 + 32'(duration_rem_sec)) == 32'(duration_sec))
	`MASD_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty)

endmodule

`default_nettype wire

>>> src/masd_front.sv
// Byte scanner: sync search, window check and header classification.
`default_nettype none

module masd_front import masd_pkg::*; #(
	parameter int unsigned SCAN_WINDOW = 4096
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [SB_W-1:0] stream_bytes,
	input  wire logic            accept,
	input  wire logic [7:0]      data_byte,
	input  wire logic            last_byte,
	output logic                 job_push,
	output job_t                 job
);

	localparam int unsigned WinW = $clog2(SCAN_WINDOW + 1);
	localparam int unsigned CmpW = WinW + 1;

	logic [7:0]      prev2_q;
	logic [7:0]      prev1_q;
	logic [WinW-1:0] pos_q;
	logic            done_q;
	logic [WinW-1:0] win;
	logic [CmpW-1:0] pos_x;
	logic [CmpW-1:0] win_x;
	logic            cand_ok;
	hdr_t            hdr;
	logic            hit;
	logic            miss;

	always_comb begin
		win = (stream_bytes < SB_W'(SCAN_WINDOW)) ? stream_bytes[WinW-1:0] :
			WinW'(SCAN_WINDOW);
		pos_x   = {1'b0, pos_q};
		win_x   = {1'b0, win};
		cand_ok = (pos_q >= WinW'(2)) && ((pos_x + CmpW'(3)) <= win_x);
		hdr     = decode_hdr(prev2_q, prev1_q, data_byte);
		hit     = !done_q && cand_ok && hdr.ok;
		miss    = !done_q && !hit && (last_byte || ((pos_x + CmpW'(4)) > win_x));
	end

	assign job_push   = accept && (hit || miss);
	assign job.found  = hit;
	assign job.kbps   = hit ? hdr.kbps : '0;
	assign job.sr     = hit ? hdr.sr : '0;
	assign job.sbytes = stream_bytes;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev2_q <= '0;
			prev1_q <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				prev2_q <= '0;
				prev1_q <= '0;
				pos_q   <= '0;
				done_q  <= 1'b0;
			end else if (!done_q) begin
				prev2_q <= prev1_q;
				prev1_q <= data_byte;
				pos_q   <= pos_q + WinW'(1);
				done_q  <= hit || miss;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/masd_jobq.sv
// Two-entry queue of classified headers between the scanner and the back end.
`default_nettype none

module masd_jobq import masd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output logic      full,
	output logic      empty
);

	job_t             mem_q [JQ_DEPTH];
	logic [JQ_AW-1:0] wr_q;
	logic [JQ_AW-1:0] rd_q;
	logic [JQ_AW:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (JQ_AW + 1)'(JQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + JQ_AW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + JQ_AW'(1);
			end
			cnt_q <= cnt_q + (JQ_AW + 1)'(do_push) - (JQ_AW + 1)'(do_pop);
		end
	end

endmodule

`default_nettype wire

>>> src/masd_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module masd_div import masd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire div_req_t   req,
	output logic            done,
	output logic [SB_W-1:0] quotient
);

	localparam int unsigned CntW = $clog2(SB_W);

	logic [DVR_W-1:0] rem_q;
	logic [SB_W-1:0]  quo_q;
	logic [DVR_W-1:0] dvr_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVR_W:0]   shifted;
	logic [DVR_W:0]   diff;
	logic             take;

	always_comb begin
		shifted = {rem_q, quo_q[SB_W-1]};
		diff    = shifted - {1'b0, dvr_q};
		take    = (shifted >= {1'b0, dvr_q});
	end

	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DVR_W-1:0] : shifted[DVR_W-1:0];
			quo_q <= {quo_q[SB_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CntW'(1);
				if (cnt_q == CntW'(SB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> src/masd_back.sv
// Back end: duration computation and the result register.
`default_nettype none

module masd_back import masd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t job,
	input  wire logic job_empty,
	output logic      job_pop,
	input  wire logic res_pop,
	output logic      res_valid,
	output result_t   res
);

	back_state_t          state_q;
	back_state_t          state_d;
	result_t              res_q;
	div_req_t             req;
	logic                 div_done;
	logic [SB_W-1:0]      quo;
	logic [RECIP_P_W-1:0] min_prod;
	logic [MIN_W-1:0]     mins;
	logic [REM_W-1:0]     secs_left;

	masd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.done     (div_done),
		.quotient (quo)
	);

	// Minutes are the seconds over four divided by fifteen through a reciprocal.
	always_comb begin
		min_prod  = RECIP_P_W'(res_q.dur[DUR_W-1:2]) * RECIP_P_W'(MIN_RECIP);
		mins      = min_prod[RECIP_SHIFT +: MIN_W];
		secs_left = REM_W'(res_q.dur - DUR_W'(mins) * DUR_W'(SECS_PER_MIN));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!job_empty) begin
					state_d = job.found ? B_DIV_SEC : B_OUT;
				end
			end
			B_DIV_SEC: begin
				if (div_done) begin
					state_d = B_DIV_MIN;
				end
			end
			B_DIV_MIN: begin
				state_d = B_OUT;
			end
			B_OUT: begin
				if (res_pop) begin
					state_d = B_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		job_pop      = 1'b0;
		res_valid    = 1'b0;
		req.start    = 1'b0;
		req.dividend = job.sbytes;
		req.divisor  = DVR_W'(job.kbps) * DVR_W'(KBPS_TO_BYTES);
		unique case (state_q)
			B_IDLE: begin
				job_pop   = !job_empty;
				req.start = !job_empty && job.found;
			end
			B_DIV_SEC: begin
			end
			B_DIV_MIN: begin
			end
			B_OUT: begin
				res_valid = 1'b1;
			end
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!job_empty) begin
					res_q.found <= job.found;
					res_q.kbps  <= job.kbps;
					res_q.sr    <= job.sr;
					res_q.dur   <= '0;
					res_q.mins  <= '0;
					res_q.rem   <= '0;
				end
			end
			B_DIV_SEC: begin
				if (div_done) begin
					res_q.dur <= quo[DUR_W-1:0];
				end
			end
			B_DIV_MIN: begin
				res_q.mins <= mins;
				res_q.rem  <= secs_left;
			end
			B_OUT: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> tb/masd_header_checker.sv
// Checker for the MPEG audio header decoder: predicts each report and compares the popped ones.
`timescale 1ns / 1ps

module masd_header_checker import masd_pkg::*; #(
	parameter int unsigned SCAN_WINDOW = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [SB_W-1:0]  cfg_wdata,
	input  wire logic             push,
	input  wire logic             full,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	input  wire logic             empty,
	input  wire logic             pop,
	input  wire logic             found,
	input  wire logic [KBPS_W-1:0] bitrate_kbps,
	input  wire logic [SR_W-1:0]  sample_rate_hz,
	input  wire logic [DUR_W-1:0] duration_sec,
	input  wire logic [MIN_W-1:0] duration_minutes,
	input  wire logic [REM_W-1:0] duration_rem_sec,
	output int unsigned           errors,
	output int unsigned           waiting
);

	localparam int unsigned POSITION_MAX = 32'h3FFFF;

	typedef struct packed {
		logic              found;
		logic [KBPS_W-1:0] kbps;
		logic [SR_W-1:0]   hz;
		logic [DUR_W-1:0]  secs;
		logic [MIN_W-1:0]  mins;
		logic [REM_W-1:0]  rem_secs;
	} header_report_t;

	int unsigned rate_mpeg1 [16];
	int unsigned rate_mpeg2 [16];
	int unsigned hz_mpeg1 [4];
	int unsigned hz_mpeg2 [4];

	logic [SB_W-1:0] audio_bytes;
	logic [7:0]      hist_two;
	logic [7:0]      hist_one;
	int unsigned     position;
	logic            reported;
	header_report_t  reports_due [$];

	initial begin
		rate_mpeg1 = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0};
		rate_mpeg2 = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0};
		hz_mpeg1   = '{44100, 48000, 32000, 0};
		hz_mpeg2   = '{22050, 24000, 16000, 0};
	end

	// Advances the sync search by one byte and queues the report it causes, if any.
	task automatic scan_byte(input logic [7:0] cur, input logic fin);
		longint unsigned win;
		longint unsigned bits_total;
		longint unsigned bits_per_sec;
		longint unsigned secs;
		logic [1:0]      ver;
		logic [1:0]      layer;
		int unsigned     rate;
		int unsigned     hz;
		header_report_t  rep;
		if (!reported) begin
			win = (64'(audio_bytes) < 64'(SCAN_WINDOW)) ? 64'(audio_bytes) : 64'(SCAN_WINDOW);
			if (position >= 2 && 64'(position) + 3 <= win) begin
				ver   = hist_one[4:3];
				layer = hist_one[2:1];
				rate  = 0;
				hz    = 0;
				if (ver == VER_MPEG1) begin
					rate = rate_mpeg1[cur[7:4]];
					hz   = hz_mpeg1[cur[3:2]];
				end else if (ver == VER_MPEG2) begin
					rate = rate_mpeg2[cur[7:4]];
					hz   = hz_mpeg2[cur[3:2]];
				end
				if (hist_two == SYNC_BYTE && hist_one[7:5] == SYNC_TOP &&
						layer == LAYER_III && rate != 0) begin
					bits_total   = 64'(audio_bytes);
					bits_total   = bits_total * 8;
					bits_per_sec = 64'(rate);
					bits_per_sec = bits_per_sec * 1000;
					secs         = bits_total / bits_per_sec;
					rep.found    = 1'b1;
					rep.kbps     = KBPS_W'(rate);
					rep.hz       = SR_W'(hz);
					rep.secs     = DUR_W'(secs);
					rep.mins     = MIN_W'(secs / 60);
					rep.rem_secs = REM_W'(secs % 60);
					reports_due.push_back(rep);
					reported = 1'b1;
				end
			end
			if (!reported && (fin || 64'(position) + 4 > win)) begin
				reports_due.push_back('0);
				reported = 1'b1;
			end
			hist_two = hist_one;
			hist_one = cur;
			if (position < POSITION_MAX)
				position++;
		end
		if (fin) begin
			hist_two = '0;
			hist_one = '0;
			position = 0;
			reported = 1'b0;
		end
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		header_report_t due;
		if (!arst_n) begin
			audio_bytes = '0;
			hist_two    = '0;
			hist_one    = '0;
			position    = 0;
			reported    = 1'b0;
			errors      = 0;
			reports_due.delete();
			waiting <= 0;
		end else begin
			if (cfg_we)
				audio_bytes = cfg_wdata;
			if (push && !full)
				scan_byte(data_byte, last_byte);
			if (pop && !empty) begin
				if (reports_due.size() == 0) begin
					$error("report transaction popped with no report expected");
					errors++;
				end else begin
					due = reports_due.pop_front();
					check_field("found", due.found, found);
					check_field("bitrate_kbps", due.kbps, bitrate_kbps);
					check_field("sample_rate_hz", due.hz, sample_rate_hz);
					check_field("duration_sec", due.secs, duration_sec);
					check_field("duration_minutes", due.mins, duration_minutes);
					check_field("duration_rem_sec", due.rem_secs, duration_rem_sec);
				end
			end
			waiting <= reports_due.size();
		end
	end

endmodule

>>> tb/mpeg_audio_sync_and_header_decode_tb.sv
// Top of the MPEG audio header decoder testbench: clock, reset, byte streams and verdict.
`timescale 1ns / 1ps

module mpeg_audio_sync_and_header_decode_tb;
	import masd_pkg::*;

	localparam int unsigned SCAN_WINDOW  = 4096;
	localparam int unsigned RANDOM_BYTES = 1100;
	localparam int unsigned DRAIN_CYCLES = 120;
	localparam int unsigned QUIET_LIMIT  = 3000;
	localparam int unsigned STEADY_FROM  = 2000;
	localparam int unsigned STEADY_TO    = 3500;
	localparam logic [SB_W-1:0] SB_MAX   = '1;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [SB_W-1:0]   cfg_wdata;
	logic              push;
	logic [7:0]        data_byte;
	logic              last_byte;
	logic              pop = 1'b0;
	logic              full;
	logic              empty;
	logic              found;
	logic [KBPS_W-1:0] bitrate_kbps;
	logic [SR_W-1:0]   sample_rate_hz;
	logic [DUR_W-1:0]  duration_sec;
	logic [MIN_W-1:0]  duration_minutes;
	logic [REM_W-1:0]  duration_rem_sec;
	int unsigned       errors;
	int unsigned       waiting;
	int unsigned       cycle = 0;
	int unsigned       quiet = 0;
	logic              steady;

	always #5 clk = ~clk;

	assign steady = (cycle >= STEADY_FROM) && (cycle < STEADY_TO);

	mpeg_audio_sync_and_header_decode #(
		.SCAN_WINDOW(SCAN_WINDOW)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.push            (push),
		.full            (full),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.empty           (empty),
		.pop             (pop),
		.found           (found),
		.bitrate_kbps    (bitrate_kbps),
		.sample_rate_hz  (sample_rate_hz),
		.duration_sec    (duration_sec),
		.duration_minutes(duration_minutes),
		.duration_rem_sec(duration_rem_sec)
	);

	masd_header_checker #(
		.SCAN_WINDOW(SCAN_WINDOW)
	) i_header_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.push            (push),
		.full            (full),
		.data_byte       (data_byte),
		.last_byte       (last_byte),
		.empty           (empty),
		.pop             (pop),
		.found           (found),
		.bitrate_kbps    (bitrate_kbps),
		.sample_rate_hz  (sample_rate_hz),
		.duration_sec    (duration_sec),
		.duration_minutes(duration_minutes),
		.duration_rem_sec(duration_rem_sec),
		.errors          (errors),
		.waiting         (waiting)
	);

	always @(posedge clk) begin
		cycle <= cycle + 1;
		pop   <= steady || ($urandom_range(0, 99) >= 10);
	end

	// The run is stopped if no transaction is taken on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (!steady && $urandom_range(0, 99) < 5) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (!(push && !full));
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_stream_bytes(input logic [SB_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int unsigned     sent;
		int unsigned     len;
		int unsigned     at;
		int unsigned     i;
		int unsigned     k;
		logic [7:0]      b;
		logic [1:0]      ver;
		logic [1:0]      layer;
		logic [63:0]     r64;
		logic [SB_W-1:0] sb;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		push      <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty window straight after reset, then a byte after the report.
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);

		write_stream_bytes(40'd8);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFB, 1'b0);
		send_byte(8'h90, 1'b0);
		send_byte(8'h00, 1'b1);

		// A find on the last byte, with the largest stream size.
		write_stream_bytes(SB_MAX);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hF3, 1'b0);
		send_byte(8'hE8, 1'b1);

		// Rejected version, bad bitrate index and bad layer before a header
		// with the reserved sample rate index.
		write_stream_bytes(40'd20);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hE3, 1'b0);
		send_byte(8'h50, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFA, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFB, 1'b0);
		send_byte(8'h9C, 1'b0);
		send_byte(8'h55, 1'b1);

		// The window shrinks in the middle of a stream.
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		write_stream_bytes(40'd4);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 99) < 35) begin
				k = $urandom_range(0, 19);
				if (k < 11) begin
					sb = SB_W'($urandom_range(0, 60));
				end else if (k < 16) begin
					r64 = {$urandom, $urandom};
					sb  = r64[SB_W-1:0];
				end else begin
					case ($urandom_range(0, 4))
						0:       sb = '0;
						1:       sb = 40'd5;
						2:       sb = 40'd4095;
						3:       sb = 40'd4096;
						default: sb = SB_MAX;
					endcase
				end
				write_stream_bytes(sb);
			end
			len = $urandom_range(1, 48);
			at  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, len - 1) : len;
			for (i = 0; i < len; i++) begin
				if (i == at) begin
					b = ($urandom_range(0, 19) == 0) ? 8'($urandom) : SYNC_BYTE;
				end else if (i == at + 1) begin
					ver = ($urandom_range(0, 9) == 0) ? 2'($urandom) :
						(($urandom_range(0, 1) != 0) ? VER_MPEG1 : VER_MPEG2);
					layer = ($urandom_range(0, 6) == 0) ? 2'($urandom) : LAYER_III;
					b = {($urandom_range(0, 19) == 0) ? 3'($urandom) : SYNC_TOP,
						ver, layer, 1'($urandom)};
				end else if (i == at + 2 || $urandom_range(0, 99) >= 8) begin
					b = 8'($urandom);
				end else begin
					b = SYNC_BYTE;
				end
				send_byte(b, i == len - 1);
				sent++;
			end
		end

		settle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
